>>> rtl/tohq_pkg.sv
// Package for the total-order hold-back queue unit.
// Holds field widths, action and status codes, the queue entry type and FSM states.
// No dependencies.
package tohq_pkg;

    localparam int QUEUE_DEPTH_DEF = 64;

    localparam logic [1:0] ACT_INITIAL  = 2'd0;
    localparam logic [1:0] ACT_PROPOSAL = 2'd1;
    localparam logic [1:0] ACT_FINAL    = 2'd2;
    localparam logic [1:0] ACT_DELIVER  = 2'd3;

    localparam logic [2:0] ST_ACCEPTED  = 3'd0;
    localparam logic [2:0] ST_DELIVERED = 3'd1;
    localparam logic [2:0] ST_ALL_DONE  = 3'd2;
    localparam logic [2:0] ST_NOTHING   = 3'd3;
    localparam logic [2:0] ST_FULL      = 3'd4;
    localparam logic [2:0] ST_NOT_FOUND = 3'd5;

    typedef struct packed {
        logic [31:0] stamp;
        logic [31:0] msg_time;
        logic        fin;
        logic [5:0]  sender;
        logic [15:0] id;
    } entry_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_FIND_RD,
        S_FIND_CHK,
        S_RM_RD,
        S_RM_WR,
        S_INS_RD,
        S_INS_CHK,
        S_HEAD_CHK,
        S_DONE
    } state_t;

endpackage

>>> rtl/tohq_if.sv
// Channel interfaces of the total-order hold-back queue unit.
// Depends on nothing; widths follow the message fields.
interface tohq_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  action;
    logic [15:0] msg_id;
    logic [5:0]  sender_id;
    logic [31:0] msg_timestamp;
    logic [31:0] final_stamp;
    modport source (output valid, action, msg_id, sender_id, msg_timestamp, final_stamp,
                    input ready);
    modport sink   (input valid, action, msg_id, sender_id, msg_timestamp, final_stamp,
                    output ready);
endinterface

interface tohq_rsp_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [15:0] out_msg_id;
    logic [5:0]  out_sender;
    logic [31:0] out_stamp;
    logic [31:0] out_timestamp;
    logic [31:0] clock_now;
    modport source (output valid, status, out_msg_id, out_sender, out_stamp, out_timestamp,
                    clock_now, input ready);
    modport sink   (input valid, status, out_msg_id, out_sender, out_stamp, out_timestamp,
                    clock_now, output ready);
endinterface

interface tohq_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] expected_count;
    modport source (output valid, expected_count, input ready);
    modport sink   (input valid, expected_count, output ready);
endinterface

>>> rtl/total_order_holdback_queue_unit.sv
// Top level of the total-order hold-back queue unit (receiver side, Lamport clock).
// Depends on tohq_pkg and the channel interfaces in tohq_if.sv.
//
// Usage: req carries one message or deliver request per transaction; rsp returns
// exactly one result per request; cfg writes expected_count at any time the unit
// is idle (cfg.ready is always high).
// The queue lives in a circular single-port-style memory (one read, one write per
// cycle, registered read data), kept sorted by (stamp, sender).
// Steps per request, from accept to the load of the output register:
//   proposal, full queue, refused deliver: straight to the output register
//   deliver request that reads the head: head read, then the final-mark check
//   initial message: a read and shift step per entry that sorts after it, then its write
//   final message: a read and compare step per position up to the id (the whole queue
//     when not found); same stamp sets the mark in place, else later entries move
//     one place toward the head and the entry is reinserted from the new tail
// Each memory step is an address state, then a state on the registered read data;
// the next request can be accepted in the same cycle that a result turns valid.
// req.ready drops while a request is in work; a finished result sits in the output
// register, so a new request is taken while rsp stalls, and the unit waits at the
// end of that request until the output register frees.
// Reset clears the clock, delivered count, queue length and head pointer; the
// memory is not cleared, since only entries below the length are read.
module total_order_holdback_queue_unit #(
    parameter int QUEUE_DEPTH = tohq_pkg::QUEUE_DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    tohq_req_if.sink    req,
    tohq_rsp_if.source  rsp,
    tohq_cfg_if.sink    cfg
);
    localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int LW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [LW:0] DEPTH_W = (LW + 1)'(QUEUE_DEPTH);

    tohq_pkg::entry_t mem [QUEUE_DEPTH];

    tohq_pkg::state_t state_reg, state_next;
    logic [31:0] clock_reg, clock_next;
    logic [15:0] delivered_reg, delivered_next;
    logic [15:0] expected_reg;
    logic [LW-1:0] len_reg, len_next;
    logic [LW-1:0] idx_reg, idx_next;
    logic [AW-1:0] head_reg, head_next;
    tohq_pkg::entry_t key_reg, key_next;
    logic [15:0] find_id_reg, find_id_next;
    tohq_pkg::entry_t rd_data_reg;

    logic [2:0]  res_status_reg, res_status_next;
    tohq_pkg::entry_t res_entry_reg, res_entry_next;
    logic [31:0] res_stamp_reg, res_stamp_next;

    logic        out_valid_reg;
    logic [2:0]  out_status_reg;
    logic [15:0] out_id_reg;
    logic [5:0]  out_sender_reg;
    logic [31:0] out_stamp_reg, out_time_reg, out_clock_reg;

    logic        mem_we, mem_re;
    logic [AW-1:0] mem_waddr, mem_raddr;
    tohq_pkg::entry_t mem_wdata;
    logic        out_load;

    logic [31:0] arr_max, arr_clock;
    logic        key_before;

    function automatic logic [AW-1:0] phys(input logic [AW-1:0] head, input logic [LW-1:0] i);
        logic [LW:0] s;
        s = (LW + 1)'(head) + (LW + 1)'(i);
        if (s >= DEPTH_W)
        begin
            s = s - DEPTH_W;
        end
        return s[AW-1:0];
    endfunction

    assign cfg.ready = 1'b1;
    assign req.ready = (state_reg == tohq_pkg::S_IDLE);

    assign arr_max   = (clock_reg > req.msg_timestamp) ? clock_reg : req.msg_timestamp;
    assign arr_clock = arr_max + 32'd1;
    assign key_before = (key_reg.stamp < rd_data_reg.stamp) ||
                        ((key_reg.stamp == rd_data_reg.stamp) &&
                         (key_reg.sender < rd_data_reg.sender));

    always_comb
    begin
        state_next      = state_reg;
        clock_next      = clock_reg;
        delivered_next  = delivered_reg;
        len_next        = len_reg;
        idx_next        = idx_reg;
        head_next       = head_reg;
        key_next        = key_reg;
        find_id_next    = find_id_reg;
        res_status_next = res_status_reg;
        res_entry_next  = res_entry_reg;
        res_stamp_next  = res_stamp_reg;
        mem_we          = 1'b0;
        mem_re          = 1'b0;
        mem_waddr       = phys(head_reg, idx_reg);
        mem_raddr       = phys(head_reg, idx_reg);
        mem_wdata       = key_reg;
        out_load        = 1'b0;

        case (state_reg)
            tohq_pkg::S_IDLE:
            begin
                if (req.valid)
                begin
                    res_status_next = tohq_pkg::ST_ACCEPTED;
                    res_entry_next  = '0;
                    res_stamp_next  = '0;
                    find_id_next    = req.msg_id;
                    state_next      = tohq_pkg::S_DONE;
                    if (req.action != tohq_pkg::ACT_DELIVER)
                    begin
                        clock_next = arr_clock;
                    end
                    case (req.action)
                        tohq_pkg::ACT_INITIAL:
                        begin
                            if ((LW + 1)'(len_reg) >= DEPTH_W)
                            begin
                                res_status_next = tohq_pkg::ST_FULL;
                            end
                            else
                            begin
                                clock_next     = arr_clock + 32'd1;
                                res_stamp_next = arr_clock;
                                key_next.stamp    = arr_clock;
                                key_next.msg_time = req.msg_timestamp;
                                key_next.fin      = 1'b0;
                                key_next.sender   = req.sender_id;
                                key_next.id       = req.msg_id;
                                idx_next   = len_reg;
                                state_next = tohq_pkg::S_INS_RD;
                            end
                        end
                        tohq_pkg::ACT_FINAL:
                        begin
                            key_next.stamp    = req.final_stamp;
                            key_next.msg_time = req.msg_timestamp;
                            key_next.fin      = 1'b1;
                            key_next.sender   = req.sender_id;
                            key_next.id       = req.msg_id;
                            idx_next   = '0;
                            state_next = tohq_pkg::S_FIND_RD;
                        end
                        tohq_pkg::ACT_DELIVER:
                        begin
                            if (delivered_reg >= expected_reg)
                            begin
                                res_status_next = tohq_pkg::ST_ALL_DONE;
                            end
                            else if (len_reg == '0)
                            begin
                                res_status_next = tohq_pkg::ST_NOTHING;
                            end
                            else
                            begin
                                mem_re     = 1'b1;
                                mem_raddr  = head_reg;
                                state_next = tohq_pkg::S_HEAD_CHK;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            tohq_pkg::S_HEAD_CHK:
            begin
                if (rd_data_reg.fin)
                begin
                    res_status_next = tohq_pkg::ST_DELIVERED;
                    res_entry_next  = rd_data_reg;
                    res_stamp_next  = rd_data_reg.stamp;
                    head_next       = phys(head_reg, LW'(1));
                    len_next        = len_reg - LW'(1);
                    delivered_next  = delivered_reg + 16'd1;
                end
                else
                begin
                    res_status_next = tohq_pkg::ST_NOTHING;
                end
                state_next = tohq_pkg::S_DONE;
            end
            tohq_pkg::S_FIND_RD:
            begin
                if (idx_reg >= len_reg)
                begin
                    res_status_next = tohq_pkg::ST_NOT_FOUND;
                    state_next      = tohq_pkg::S_DONE;
                end
                else
                begin
                    mem_re     = 1'b1;
                    state_next = tohq_pkg::S_FIND_CHK;
                end
            end
            tohq_pkg::S_FIND_CHK:
            begin
                if (rd_data_reg.id == find_id_reg)
                begin
                    if (rd_data_reg.stamp == key_reg.stamp)
                    begin
                        // same stamp: set the final mark in place
                        mem_we        = 1'b1;
                        mem_wdata     = rd_data_reg;
                        mem_wdata.fin = 1'b1;
                        state_next    = tohq_pkg::S_DONE;
                    end
                    else
                    begin
                        state_next = tohq_pkg::S_RM_RD;
                    end
                end
                else
                begin
                    idx_next   = idx_reg + LW'(1);
                    state_next = tohq_pkg::S_FIND_RD;
                end
            end
            tohq_pkg::S_RM_RD:
            begin
                if ((idx_reg + LW'(1)) < len_reg)
                begin
                    mem_re     = 1'b1;
                    mem_raddr  = phys(head_reg, idx_reg + LW'(1));
                    state_next = tohq_pkg::S_RM_WR;
                end
                else
                begin
                    // entry removed; reinsert from the new tail
                    len_next   = len_reg - LW'(1);
                    idx_next   = len_reg - LW'(1);
                    state_next = tohq_pkg::S_INS_RD;
                end
            end
            tohq_pkg::S_RM_WR:
            begin
                mem_we     = 1'b1;
                mem_wdata  = rd_data_reg;
                idx_next   = idx_reg + LW'(1);
                state_next = tohq_pkg::S_RM_RD;
            end
            tohq_pkg::S_INS_RD:
            begin
                if (idx_reg == '0)
                begin
                    mem_we     = 1'b1;
                    len_next   = len_reg + LW'(1);
                    state_next = tohq_pkg::S_DONE;
                end
                else
                begin
                    mem_re     = 1'b1;
                    mem_raddr  = phys(head_reg, idx_reg - LW'(1));
                    state_next = tohq_pkg::S_INS_CHK;
                end
            end
            tohq_pkg::S_INS_CHK:
            begin
                mem_we = 1'b1;
                if (key_before)
                begin
                    // shift the larger entry one place toward the tail
                    mem_wdata  = rd_data_reg;
                    idx_next   = idx_reg - LW'(1);
                    state_next = tohq_pkg::S_INS_RD;
                end
                else
                begin
                    len_next   = len_reg + LW'(1);
                    state_next = tohq_pkg::S_DONE;
                end
            end
            tohq_pkg::S_DONE:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_load   = 1'b1;
                    state_next = tohq_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = tohq_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= tohq_pkg::S_IDLE;
            clock_reg     <= '0;
            delivered_reg <= '0;
            expected_reg  <= '0;
            len_reg       <= '0;
            idx_reg       <= '0;
            head_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clock_reg     <= clock_next;
            delivered_reg <= delivered_next;
            len_reg       <= len_next;
            idx_reg       <= idx_next;
            head_reg      <= head_next;
            if (cfg.valid)
            begin
                expected_reg <= cfg.expected_count;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg        <= key_next;
        find_id_reg    <= find_id_next;
        res_status_reg <= res_status_next;
        res_entry_reg  <= res_entry_next;
        res_stamp_reg  <= res_stamp_next;
        if (out_load)
        begin
            out_status_reg <= res_status_reg;
            out_id_reg     <= res_entry_reg.id;
            out_sender_reg <= res_entry_reg.sender;
            out_stamp_reg  <= res_stamp_reg;
            out_time_reg   <= res_entry_reg.msg_time;
            out_clock_reg  <= clock_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[mem_raddr];
        end
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.status        = out_status_reg;
    assign rsp.out_msg_id    = out_id_reg;
    assign rsp.out_sender    = out_sender_reg;
    assign rsp.out_stamp     = out_stamp_reg;
    assign rsp.out_timestamp = out_time_reg;
    assign rsp.clock_now     = out_clock_reg;

endmodule
